// ----- design/chsa_pkg.sv -----
package chsa_pkg;

  localparam int unsigned TRIG_FRAC_BITS_DEFAULT = 15;

  // sine and cosine series run in Q2.30
  localparam int unsigned WORK_BITS = 30;
  localparam int unsigned SERIES_TERMS = 6;

  // angle front end, series cells, rounding and quadrant stage
  localparam int unsigned TRIG_LATENCY = 6 + 2 * SERIES_TERMS + 1;

  localparam int unsigned HUE_W = 16;
  localparam int unsigned SAT_W = 9;
  localparam int unsigned CHROMA_W = 8;
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W = 16;

  typedef logic [HUE_W-1:0] hue_t;
  typedef logic signed [SAT_W-1:0] sat_t;
  typedef logic [CHROMA_W-1:0] chroma_t;

  localparam logic [CFG_INDEX_W-1:0] REG_HUE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_SAT = 1'b1;

  localparam hue_t HUE_RESET = 16'd4500;
  localparam sat_t SAT_RESET = 9'sd116;

  localparam int CHROMA_BIAS = 128;
  localparam int PERCENT = 100;

endpackage

// ----- design/chsa_trig_cell.sv -----
module chsa_trig_cell import chsa_pkg::*; #(
  parameter int unsigned DIVISOR = 2,
  parameter bit SUBTRACT = 1'b1
) (
  input  logic                        clk,
  input  logic [WORK_BITS:0]          term_in,
  input  logic signed [WORK_BITS+1:0] sum_in,
  input  logic [WORK_BITS-1:0]        x2_in,
  output logic [WORK_BITS:0]          term_out,
  output logic signed [WORK_BITS+1:0] sum_out,
  output logic [WORK_BITS-1:0]        x2_out
);

  localparam int unsigned PROD_W = 2 * WORK_BITS + 1;
  // reciprocal exact for every dividend below 2^WORK_BITS
  localparam int unsigned SHIFT = WORK_BITS + $clog2(DIVISOR);
  localparam logic [63:0] RECIP_WIDE =
    ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [WORK_BITS:0] RECIP = RECIP_WIDE[WORK_BITS:0];

  logic [PROD_W-1:0]           prod;
  logic [WORK_BITS-1:0]        part;
  logic signed [WORK_BITS+1:0] sum_mid;
  logic [WORK_BITS-1:0]        x2_mid;
  logic [PROD_W-1:0]           qprod;
  logic [PROD_W-1:0]           qshift;
  logic [WORK_BITS-1:0]        quot;
  logic signed [WORK_BITS+1:0] quot_ext;

  assign prod = PROD_W'(term_in) * PROD_W'(x2_in);

  always_ff @(posedge clk) begin
    part    <= prod[2*WORK_BITS-1:WORK_BITS];
    sum_mid <= sum_in;
    x2_mid  <= x2_in;
  end

  assign qprod    = PROD_W'(part) * PROD_W'(RECIP);
  assign qshift   = qprod >> SHIFT;
  assign quot     = qshift[WORK_BITS-1:0];
  assign quot_ext = $signed({2'b00, quot});

  always_ff @(posedge clk) begin
    term_out <= {1'b0, quot};
    sum_out  <= SUBTRACT ? sum_mid - quot_ext : sum_mid + quot_ext;
    x2_out   <= x2_mid;
  end

endmodule

// ----- design/chsa_trig.sv -----
module chsa_trig import chsa_pkg::*; #(
  parameter int unsigned FRAC_BITS = TRIG_FRAC_BITS_DEFAULT
) (
  input  logic                       clk,
  input  hue_t                       hue,
  output logic signed [FRAC_BITS+1:0] cos_val,
  output logic signed [FRAC_BITS+1:0] sin_val
);

  localparam hue_t FULL_TURN = 16'd36000;
  localparam logic [13:0] QUARTER_TURN = 14'd9000;
  localparam logic [13:0] EIGHTH_TURN = 14'd4500;
  // pi/18000 in Q2.30 split into whole part and remainder over 18000
  localparam logic [17:0] X_WHOLE = 18'd187403;
  localparam logic [12:0] X_REM = 13'd5426;
  // floor(z / 1125) for z below 2^21, after a shift by 4 (18000 = 16 * 1125)
  localparam logic [20:0] X_RECIP = 21'd1908875;
  localparam int unsigned X_SHIFT = 31;
  localparam int unsigned ROUND_SHIFT = WORK_BITS - FRAC_BITS;
  localparam logic [WORK_BITS+1:0] ROUND_HALF = (WORK_BITS+2)'(1) << (ROUND_SHIFT - 1);
  localparam logic [WORK_BITS:0] ONE = (WORK_BITS+1)'(1) << WORK_BITS;

  hue_t                   angle;
  logic [1:0]             quad;
  logic                   swap;
  logic [12:0]            tt;
  logic [29:0]            x_hi;
  logic [24:0]            x_rem;
  logic [29:0]            x_hi_d;
  logic [10:0]            x_frac;
  logic [WORK_BITS-1:0]   x;
  logic [WORK_BITS-1:0]   x_d;
  logic [WORK_BITS-1:0]   x2;

  hue_t                   a_sub;
  logic [13:0]            t_raw;
  logic [1:0]             quad_raw;
  logic [41:0]            frac_prod;
  logic [2*WORK_BITS-1:0] sq;

  always_comb begin
    a_sub = angle;
    quad_raw = 2'd0;
    if (angle >= 16'd27000) begin
      a_sub = angle - 16'd27000;
      quad_raw = 2'd3;
    end else if (angle >= 16'd18000) begin
      a_sub = angle - 16'd18000;
      quad_raw = 2'd2;
    end else if (angle >= 16'd9000) begin
      a_sub = angle - 16'd9000;
      quad_raw = 2'd1;
    end
    t_raw = a_sub[13:0];
  end

  assign frac_prod = 42'(x_rem >> 4) * 42'(X_RECIP);
  assign sq = (2*WORK_BITS)'(x) * (2*WORK_BITS)'(x);

  always_ff @(posedge clk) begin
    angle  <= (hue >= FULL_TURN) ? hue - FULL_TURN : hue;
    quad   <= quad_raw;
    swap   <= t_raw > EIGHTH_TURN;
    tt     <= (t_raw > EIGHTH_TURN) ? 13'(QUARTER_TURN - t_raw) : t_raw[12:0];
    x_hi   <= 30'(30'(tt) * 30'(X_WHOLE));
    x_rem  <= 25'(25'(tt) * 25'(X_REM));
    x_hi_d <= x_hi;
    x_frac <= frac_prod[X_SHIFT+10:X_SHIFT];
    x      <= x_hi_d + 30'(x_frac);
    x2     <= sq[2*WORK_BITS-1:WORK_BITS];
    x_d    <= x;
  end

  logic [WORK_BITS:0]          sin_term [0:SERIES_TERMS];
  logic signed [WORK_BITS+1:0] sin_sum  [0:SERIES_TERMS];
  logic [WORK_BITS-1:0]        sin_x2   [0:SERIES_TERMS];
  logic [WORK_BITS:0]          cos_term [0:SERIES_TERMS];
  logic signed [WORK_BITS+1:0] cos_sum  [0:SERIES_TERMS];
  logic [WORK_BITS-1:0]        cos_x2   [0:SERIES_TERMS];

  assign sin_term[0] = {1'b0, x_d};
  assign sin_sum[0]  = $signed({2'b00, x_d});
  assign sin_x2[0]   = x2;
  assign cos_term[0] = ONE;
  assign cos_sum[0]  = $signed({1'b0, ONE});
  assign cos_x2[0]   = x2;

  // each cell adds one series term, signs alternating
  for (genvar k = 0; k < SERIES_TERMS; k++) begin : g_series
    chsa_trig_cell #(
      .DIVISOR  ((2*k+2) * (2*k+3)),
      .SUBTRACT (k % 2 == 0)
    ) u_sin_cell (
      .clk      (clk),
      .term_in  (sin_term[k]),
      .sum_in   (sin_sum[k]),
      .x2_in    (sin_x2[k]),
      .term_out (sin_term[k+1]),
      .sum_out  (sin_sum[k+1]),
      .x2_out   (sin_x2[k+1])
    );
    chsa_trig_cell #(
      .DIVISOR  ((2*k+1) * (2*k+2)),
      .SUBTRACT (k % 2 == 0)
    ) u_cos_cell (
      .clk      (clk),
      .term_in  (cos_term[k]),
      .sum_in   (cos_sum[k]),
      .x2_in    (cos_x2[k]),
      .term_out (cos_term[k+1]),
      .sum_out  (cos_sum[k+1]),
      .x2_out   (cos_x2[k+1])
    );
  end

  logic [WORK_BITS:0]   sin_pos;
  logic [WORK_BITS:0]   cos_pos;
  logic [WORK_BITS+1:0] sin_rnd;
  logic [WORK_BITS+1:0] cos_rnd;
  logic [FRAC_BITS:0]   s_mag;
  logic [FRAC_BITS:0]   c_mag;
  logic signed [FRAC_BITS+1:0] s_val;
  logic signed [FRAC_BITS+1:0] c_val;
  logic signed [FRAC_BITS+1:0] sin_sel;
  logic signed [FRAC_BITS+1:0] cos_sel;

  always_comb begin
    // negative series sums read as zero
    sin_pos = sin_sum[SERIES_TERMS][WORK_BITS+1] ? '0 : sin_sum[SERIES_TERMS][WORK_BITS:0];
    cos_pos = cos_sum[SERIES_TERMS][WORK_BITS+1] ? '0 : cos_sum[SERIES_TERMS][WORK_BITS:0];
    sin_rnd = ({1'b0, sin_pos} + ROUND_HALF) >> ROUND_SHIFT;
    cos_rnd = ({1'b0, cos_pos} + ROUND_HALF) >> ROUND_SHIFT;
    s_mag = swap ? cos_rnd[FRAC_BITS:0] : sin_rnd[FRAC_BITS:0];
    c_mag = swap ? sin_rnd[FRAC_BITS:0] : cos_rnd[FRAC_BITS:0];
    s_val = $signed({1'b0, s_mag});
    c_val = $signed({1'b0, c_mag});
    case (quad)
      2'd0: begin
        sin_sel = s_val;
        cos_sel = c_val;
      end
      2'd1: begin
        sin_sel = c_val;
        cos_sel = -s_val;
      end
      2'd2: begin
        sin_sel = -s_val;
        cos_sel = -c_val;
      end
      default: begin
        sin_sel = -c_val;
        cos_sel = s_val;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    sin_val <= sin_sel;
    cos_val <= cos_sel;
  end

endmodule

// ----- design/chsa_mix.sv -----
module chsa_mix import chsa_pkg::*; #(
  parameter int unsigned FRAC_BITS = TRIG_FRAC_BITS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  chroma_t                     cb_in,
  input  chroma_t                     cr_in,
  input  sat_t                        sat,
  input  logic signed [FRAC_BITS+1:0] cos_val,
  input  logic signed [FRAC_BITS+1:0] sin_val,
  output logic                        out_valid,
  input  logic                        out_ready,
  output chroma_t                     cb_out,
  output chroma_t                     cr_out
);

  localparam int unsigned DOT_W = FRAC_BITS + 12;
  localparam int unsigned PROD_W = DOT_W + SAT_W;
  localparam int unsigned M_W = PROD_W - FRAC_BITS;
  // floor(m / 100) + 128 stays in 0..255 only for m in this range
  localparam int RANGE_LO = -(CHROMA_BIAS * PERCENT);
  localparam int RANGE_HI = (256 - CHROMA_BIAS) * PERCENT - 1;
  localparam logic [12:0] DIV100_RECIP = 13'd5243;
  localparam int unsigned DIV100_SHIFT = 19;
  localparam logic [8:0] BIAS9 = 9'(CHROMA_BIAS);

  function automatic chroma_t finish_chroma(input logic signed [M_W-1:0] m);
    logic signed [M_W-1:0] mc;
    logic [14:0] off;
    logic [27:0] prod;
    if (m < RANGE_LO) begin
      mc = M_W'(RANGE_LO);
    end else if (m > RANGE_HI) begin
      mc = M_W'(RANGE_HI);
    end else begin
      mc = m;
    end
    off = 15'(mc - M_W'(RANGE_LO));
    prod = 28'(off) * 28'(DIV100_RECIP);
    return prod[DIV100_SHIFT+7:DIV100_SHIFT];
  endfunction

  logic v0;
  logic v1;
  logic v2;
  logic en0;
  logic en1;
  logic en2;
  logic en3;

  // each stage moves when the one after it can take the item
  assign en3 = !out_valid || out_ready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign en0 = !v0 || en1;
  assign in_ready = en0;

  logic signed [8:0] b0;
  logic signed [8:0] r0;
  logic              neutral0;
  chroma_t           cb0;
  chroma_t           cr0;
  logic signed [8:0] b_in;
  logic signed [8:0] r_in;

  assign b_in = $signed({1'b0, cb_in} - BIAS9);
  assign r_in = $signed({1'b0, cr_in} - BIAS9);

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en0) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en0 && in_valid) begin
      b0       <= b_in;
      r0       <= r_in;
      neutral0 <= (b_in == 9'sd0) || (r_in == 9'sd0);
      cb0      <= cb_in;
      cr0      <= cr_in;
    end
  end

  logic signed [DOT_W-1:0] dot_b1;
  logic signed [DOT_W-1:0] dot_r1;
  logic                    neutral1;
  chroma_t                 cb1;
  chroma_t                 cr1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && v0) begin
      dot_b1   <= DOT_W'(b0) * DOT_W'(cos_val) + DOT_W'(r0) * DOT_W'(sin_val);
      dot_r1   <= DOT_W'(r0) * DOT_W'(cos_val) - DOT_W'(b0) * DOT_W'(sin_val);
      neutral1 <= neutral0;
      cb1      <= cb0;
      cr1      <= cr0;
    end
  end

  logic signed [PROD_W-1:0] gain_b;
  logic signed [PROD_W-1:0] gain_r;
  logic signed [PROD_W-1:0] floor_b;
  logic signed [PROD_W-1:0] floor_r;
  logic signed [M_W-1:0]    m_b2;
  logic signed [M_W-1:0]    m_r2;
  logic                     neutral2;
  chroma_t                  cb2;
  chroma_t                  cr2;

  // arithmetic shift floors the division by 2^FRAC_BITS
  assign gain_b  = PROD_W'(sat) * PROD_W'(dot_b1);
  assign gain_r  = PROD_W'(sat) * PROD_W'(dot_r1);
  assign floor_b = gain_b >>> FRAC_BITS;
  assign floor_r = gain_r >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      m_b2     <= floor_b[M_W-1:0];
      m_r2     <= floor_r[M_W-1:0];
      neutral2 <= neutral1;
      cb2      <= cb1;
      cr2      <= cr1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en3) begin
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      cb_out <= neutral2 ? cb2 : finish_chroma(m_b2);
      cr_out <= neutral2 ? cr2 : finish_chroma(m_r2);
    end
  end

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    v1 && !en1 |=> v1 && $stable(dot_b1) && $stable(dot_r1))
    else $error("stalled stage lost its products");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !v0 && !v1 && !v2 && !out_valid)
    else $error("pipeline not empty after reset");

endmodule

// ----- design/chroma_hue_saturation_adjust.sv -----
// Rotates a (Cb, Cr) chroma pair by the hue angle and scales it by the saturation
// gain in percent, one pair per clock sustained while the output is ready and the
// trig pipeline has settled. A pair with either byte at the neutral value 128 passes
// unchanged. Each pair passes through the input register, which takes it at the
// transfer, then dot products, gain, and rounding and clamp into the output
// register, and input keeps flowing while a result waits as long as a stage is free.
// Sine and cosine come from the hue register through series cells, twelve in all,
// one chain each for sine and cosine; after reset and after every hue write the input
// stays not ready while that pipeline settles. Saturation writes take effect at once.
// Configuration must be written only while no transfer is in flight; the block itself does not enforce this.
module chroma_hue_saturation_adjust import chsa_pkg::*; #(
  parameter int unsigned TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  chroma_t                cb_in,
  input  chroma_t                cr_in,
  output logic                   out_valid,
  input  logic                   out_ready,
  output chroma_t                cb_out,
  output chroma_t                cr_out
);

  localparam int unsigned SETTLE_W = $clog2(TRIG_LATENCY + 1);
  localparam logic [SETTLE_W-1:0] SETTLE_LOAD = SETTLE_W'(TRIG_LATENCY);
  localparam logic signed [TRIG_FRAC_BITS+1:0] TRIG_ONE = {2'b01, {TRIG_FRAC_BITS{1'b0}}};

  hue_t hue;
  sat_t sat;
  logic [SETTLE_W-1:0] settle;
  logic settled;
  logic mix_ready;
  logic signed [TRIG_FRAC_BITS+1:0] cos_val;
  logic signed [TRIG_FRAC_BITS+1:0] sin_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      hue <= HUE_RESET;
      sat <= SAT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_HUE: hue <= cfg_data[HUE_W-1:0];
        REG_SAT: sat <= cfg_data[SAT_W-1:0];
      endcase
    end
  end

  // hold off input until the trig pipeline reflects the current hue
  always_ff @(posedge clk) begin
    if (rst) begin
      settle <= SETTLE_LOAD;
    end else if (cfg_write && cfg_index == REG_HUE) begin
      settle <= SETTLE_LOAD;
    end else if (settle != '0) begin
      settle <= settle - 1'b1;
    end
  end

  assign settled = (settle == '0);
  assign in_ready = mix_ready && settled;

  chsa_trig #(
    .FRAC_BITS (TRIG_FRAC_BITS)
  ) u_trig (
    .clk     (clk),
    .hue     (hue),
    .cos_val (cos_val),
    .sin_val (sin_val)
  );

  chsa_mix #(
    .FRAC_BITS (TRIG_FRAC_BITS)
  ) u_mix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid && settled),
    .in_ready  (mix_ready),
    .cb_in     (cb_in),
    .cr_in     (cr_in),
    .sat       (sat),
    .cos_val   (cos_val),
    .sin_val   (sin_val),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cb_out    (cb_out),
    .cr_out    (cr_out)
  );

  a_hue_write_blocks: assert property (@(posedge clk) disable iff (rst)
    cfg_write && cfg_index == REG_HUE |=> !in_ready)
    else $error("input taken right after a hue write");

  a_trig_range: assert property (@(posedge clk) disable iff (rst)
    settled |-> cos_val <= TRIG_ONE && cos_val >= -TRIG_ONE &&
                sin_val <= TRIG_ONE && sin_val >= -TRIG_ONE)
    else $error("sine or cosine beyond unit magnitude");

endmodule
